FILE: rtl/core/rpn_stack_evaluator_macros.svh
// Assertion macros for the checker file of the RPN evaluator.
`ifndef RPN_STACK_EVALUATOR_MACROS_SVH
`define RPN_STACK_EVALUATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPN_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RPN_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rpn_pkg.sv
package rpn_pkg;

    localparam int DEFAULT_STACK_DEPTH = 16;

    localparam int VALUE_W    = 64;
    localparam int FRAC_W     = 32;
    localparam int OPERAND_W  = 32;
    localparam int OPCODE_W   = 2;
    localparam int STATUS_W   = 3;
    localparam int S_TDATA_W  = 40;
    localparam int OPCODE_LSB = OPERAND_W;

    typedef logic [VALUE_W-1:0] fx_t;

    localparam fx_t FX_POS_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam fx_t FX_NEG_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_OPER = 1'b1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_UNDER,
        ST_OVER,
        ST_DIVZERO,
        ST_SAT
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD_A,
        S_START,
        S_MUL,
        S_DIV,
        S_WB,
        S_CHECK_END,
        S_EMIT
    } ctrl_state_t;

    typedef enum logic {
        RD_TOP,
        RD_SECOND
    } rd_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_token;
        logic    push;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    take_b;
        logic    alu_start;
        logic    res_from_mul;
        logic    res_from_div;
        logic    write_back;
        logic    flag_en;
        status_t flag_code;
        logic    emit;
    } dp_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic    kind;
        opcode_t opcode;
        logic    last;
        logic    empty;
        logic    full;
        logic    lt2;
        logic    b_zero;
        logic    mul_done;
        logic    div_done;
        logic    out_free;
    } dp_stat_t;

    typedef struct packed {
        fx_t  value;
        logic sat;
    } sat_res_t;

    function automatic fx_t fx_mag(fx_t v);
        return v[VALUE_W-1] ? (~v + fx_t'(1)) : v;
    endfunction

    // Applies a sign to an unsigned magnitude and clamps to the signed range.
    function automatic sat_res_t sat_apply(fx_t mag, logic neg, logic ovf);
        sat_res_t r;
        if (neg) begin
            if (ovf || (mag > FX_NEG_MIN)) begin
                r.value = FX_NEG_MIN;
                r.sat   = 1'b1;
            end else begin
                r.value = ~mag + fx_t'(1);
                r.sat   = 1'b0;
            end
        end else begin
            if (ovf || (mag > FX_POS_MAX)) begin
                r.value = FX_POS_MAX;
                r.sat   = 1'b1;
            end else begin
                r.value = mag;
                r.sat   = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic sat_res_t fx_addsub(fx_t a, fx_t b, logic sub);
        sat_res_t r;
        fx_t      sum;
        logic     ovf;
        sum = sub ? (a - b) : (a + b);
        if (sub) begin
            ovf = (a[VALUE_W-1] != b[VALUE_W-1]) && (sum[VALUE_W-1] != a[VALUE_W-1]);
        end else begin
            ovf = (a[VALUE_W-1] == b[VALUE_W-1]) && (sum[VALUE_W-1] != a[VALUE_W-1]);
        end
        r.sat   = ovf;
        r.value = ovf ? (a[VALUE_W-1] ? FX_NEG_MIN : FX_POS_MAX) : sum;
        return r;
    endfunction

endpackage

FILE: rtl/core/rpn_mul.sv
// Unsigned 64 x 64 multiply on one shared 32 x 32 multiplier, four partial
// products accumulated in turn. Gives bits [95:32] of the product
// and a flag for any nonzero bit above them.
module rpn_mul
    import rpn_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic start,
    input  fx_t  a_mag,
    input  fx_t  b_mag,
    output logic done,
    output fx_t  mag,
    output logic ovf
);

    localparam int HALF_W = VALUE_W / 2;
    localparam int PROD_W = 2 * VALUE_W;

    logic                busy_reg;
    logic                done_reg;
    logic [2:0]          step_reg;
    fx_t                 a_reg;
    fx_t                 b_reg;
    logic [VALUE_W-1:0]  pp_reg;
    logic [1:0]          sh_reg;
    logic [PROD_W-1:0]   acc_reg;

    logic [HALF_W-1:0]   a_part;
    logic [HALF_W-1:0]   b_part;
    logic [PROD_W-1:0]   pp_shifted;

    assign a_part = step_reg[1] ? a_reg[VALUE_W-1:HALF_W] : a_reg[HALF_W-1:0];
    assign b_part = step_reg[0] ? b_reg[VALUE_W-1:HALF_W] : b_reg[HALF_W-1:0];

    always_comb begin
        unique case (sh_reg)
            2'd0:    pp_shifted = {{VALUE_W{1'b0}}, pp_reg};
            2'd1:    pp_shifted = {{HALF_W{1'b0}}, pp_reg, {HALF_W{1'b0}}};
            default: pp_shifted = {pp_reg, {VALUE_W{1'b0}}};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a_mag;
            b_reg   <= b_mag;
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (step_reg != 3'd4) begin
                pp_reg <= a_part * b_part;
                sh_reg <= 2'(step_reg[1]) + 2'(step_reg[0]);
            end
            if (step_reg != 3'd0) begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end
    end

    assign done = done_reg;
    assign mag  = acc_reg[VALUE_W+FRAC_W-1:FRAC_W];
    assign ovf  = |acc_reg[PROD_W-1:VALUE_W+FRAC_W];

endmodule

FILE: rtl/core/rpn_div.sv
// Restoring radix-2 divider: (a << 32) / b on magnitudes, one quotient bit
// per cycle for 96 bits. Quotient bits that shift out of 64 bits set ovf.
module rpn_div
    import rpn_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic start,
    input  fx_t  a_mag,
    input  fx_t  b_mag,
    output logic done,
    output fx_t  quot,
    output logic ovf
);

    localparam int STEPS   = VALUE_W + FRAC_W;
    localparam int CNT_W   = $clog2(STEPS);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    fx_t               rem_reg;
    fx_t               q_reg;
    fx_t               dvd_reg;
    fx_t               dvs_reg;
    logic              ovf_reg;

    logic [VALUE_W:0]  rem_sh;
    logic [VALUE_W:0]  diff;
    logic              ge;

    assign rem_sh = {rem_reg, dvd_reg[VALUE_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            q_reg   <= '0;
            dvd_reg <= a_mag;
            dvs_reg <= b_mag;
            ovf_reg <= 1'b0;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[VALUE_W-1:0] : rem_sh[VALUE_W-1:0];
            q_reg   <= {q_reg[VALUE_W-2:0], ge};
            ovf_reg <= ovf_reg | q_reg[VALUE_W-1];
            dvd_reg <= {dvd_reg[VALUE_W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign ovf  = ovf_reg;

endmodule

FILE: rtl/core/rpn_datapath.sv
// Token registers, value stack, arithmetic units, status and output register.
module rpn_datapath
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [VALUE_W-1:0]   m_tdata,
    output logic [STATUS_W-1:0]  m_tuser,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    fx_t stack_mem [STACK_DEPTH];

    logic                  kind_reg;
    opcode_t               opcode_reg;
    logic                  last_reg;
    logic [OPERAND_W-1:0]  operand_reg;
    logic [CW-1:0]         count_reg;
    status_t               status_reg;
    fx_t                   rd_data_reg;
    fx_t                   b_reg;
    fx_t                   res_reg;
    logic                  neg_reg;
    logic                  out_valid_reg;
    fx_t                   out_value_reg;
    status_t               out_status_reg;

    logic [AW-1:0]  top_addr;
    logic [AW-1:0]  second_addr;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    fx_t            wr_data;
    logic           wr_en;
    fx_t            a_val;
    sat_res_t       addsub_res;
    sat_res_t       mul_res;
    sat_res_t       div_res;
    logic           mul_done;
    fx_t            mul_mag;
    logic           mul_ovf;
    logic           div_done;
    fx_t            div_quot;
    logic           div_ovf;
    logic           mul_start;
    logic           div_start;
    logic           flag_en;
    status_t        flag_code;

    // The second operand was read last, so it sits in the read register.
    assign a_val       = rd_data_reg;
    assign top_addr    = AW'(count_reg - CW'(1));
    assign second_addr = AW'(count_reg - CW'(2));
    assign rd_addr     = (cmd.rd_sel == RD_SECOND) ? second_addr : top_addr;

    assign addsub_res = fx_addsub(a_val, b_reg, opcode_reg == OP_SUB);
    assign mul_res    = sat_apply(mul_mag, neg_reg, mul_ovf);
    // A zero quotient is never negative, even when its bits overflowed.
    assign div_res    = sat_apply(div_quot, neg_reg && (div_quot != '0), div_ovf);

    assign mul_start = cmd.alu_start && (opcode_reg == OP_MUL);
    assign div_start = cmd.alu_start && (opcode_reg == OP_DIV) && (b_reg != '0);

    rpn_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a_mag   (fx_mag(a_val)),
        .b_mag   (fx_mag(b_reg)),
        .done    (mul_done),
        .mag     (mul_mag),
        .ovf     (mul_ovf)
    );

    rpn_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .a_mag   (fx_mag(a_val)),
        .b_mag   (fx_mag(b_reg)),
        .done    (div_done),
        .quot    (div_quot),
        .ovf     (div_ovf)
    );

    // Only one source can raise an error code in any cycle.
    always_comb begin
        flag_en   = 1'b0;
        flag_code = ST_OK;
        priority if (cmd.flag_en) begin
            flag_en   = 1'b1;
            flag_code = cmd.flag_code;
        end else if (cmd.alu_start && (opcode_reg == OP_DIV) && (b_reg == '0)) begin
            flag_en   = 1'b1;
            flag_code = ST_DIVZERO;
        end else if (cmd.alu_start && ((opcode_reg == OP_ADD) || (opcode_reg == OP_SUB))
                     && addsub_res.sat) begin
            flag_en   = 1'b1;
            flag_code = ST_SAT;
        end else if (cmd.res_from_mul && mul_res.sat) begin
            flag_en   = 1'b1;
            flag_code = ST_SAT;
        end else if (cmd.res_from_div && div_res.sat) begin
            flag_en   = 1'b1;
            flag_code = ST_SAT;
        end else begin
            flag_en   = 1'b0;
        end
    end

    always_comb begin
        wr_en   = cmd.push || cmd.write_back;
        wr_addr = cmd.push ? count_reg[AW-1:0] : second_addr;
        wr_data = cmd.push ? {operand_reg, {FRAC_W{1'b0}}} : res_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_token) begin
            kind_reg    <= s_tuser;
            operand_reg <= s_tdata[OPERAND_W-1:0];
            opcode_reg  <= opcode_t'(s_tdata[OPCODE_LSB+OPCODE_W-1:OPCODE_LSB]);
            last_reg    <= s_tlast;
        end
        if (cmd.take_b) begin
            b_reg <= rd_data_reg;
        end
        if (cmd.alu_start) begin
            neg_reg <= a_val[VALUE_W-1] ^ b_reg[VALUE_W-1];
            res_reg <= (opcode_reg == OP_DIV) ? '0 : addsub_res.value;
        end else if (cmd.res_from_mul) begin
            res_reg <= mul_res.value;
        end else if (cmd.res_from_div) begin
            res_reg <= div_res.value;
        end
        if (cmd.emit) begin
            out_value_reg  <= (count_reg == '0) ? '0 : rd_data_reg;
            out_status_reg <= status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.emit) begin
                count_reg  <= '0;
                status_reg <= ST_OK;
            end else begin
                if (cmd.push) begin
                    count_reg <= count_reg + CW'(1);
                end else if (cmd.write_back) begin
                    count_reg <= count_reg - CW'(1);
                end
                // First error of the expression is kept.
                if (flag_en && (status_reg == ST_OK)) begin
                    status_reg <= flag_code;
                end
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        stat.kind     = kind_reg;
        stat.opcode   = opcode_reg;
        stat.last     = last_reg;
        stat.empty    = (count_reg == '0);
        stat.full     = (count_reg >= CW'(STACK_DEPTH));
        stat.lt2      = (count_reg < CW'(2));
        stat.b_zero   = (b_reg == '0);
        stat.mul_done = mul_done;
        stat.div_done = div_done;
        stat.out_free = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;

endmodule

FILE: rtl/core/rpn_ctrl.sv
// Token sequencer: decodes each token and steps the datapath through
// stack reads, the arithmetic unit, write-back and the end-of-expression pop.
module rpn_ctrl
    import rpn_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_token = 1'b1;
                    state_next     = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.kind == KIND_PUSH) begin
                    if (stat.full) begin
                        cmd.flag_en   = 1'b1;
                        cmd.flag_code = ST_OVER;
                    end else begin
                        cmd.push = 1'b1;
                    end
                    state_next = S_CHECK_END;
                end else if (stat.lt2) begin
                    cmd.flag_en   = 1'b1;
                    cmd.flag_code = ST_UNDER;
                    state_next    = S_CHECK_END;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_TOP;
                    state_next = S_RD_A;
                end
            end
            S_RD_A: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_SECOND;
                cmd.take_b = 1'b1;
                state_next = S_START;
            end
            S_START: begin
                cmd.alu_start = 1'b1;
                unique case (stat.opcode)
                    OP_ADD, OP_SUB: state_next = S_WB;
                    OP_MUL:         state_next = S_MUL;
                    OP_DIV:         state_next = stat.b_zero ? S_WB : S_DIV;
                    default:        state_next = S_WB;
                endcase
            end
            S_MUL: begin
                if (stat.mul_done) begin
                    cmd.res_from_mul = 1'b1;
                    state_next       = S_WB;
                end
            end
            S_DIV: begin
                if (stat.div_done) begin
                    cmd.res_from_div = 1'b1;
                    state_next       = S_WB;
                end
            end
            S_WB: begin
                cmd.write_back = 1'b1;
                state_next     = S_CHECK_END;
            end
            S_CHECK_END: begin
                if (!stat.last) begin
                    state_next = S_IDLE;
                end else begin
                    if (stat.empty) begin
                        cmd.flag_en   = 1'b1;
                        cmd.flag_code = ST_UNDER;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_TOP;
                    end
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/rpn_stack_evaluator.sv
// Channel  Direction  tdata                               tuser          tlast
// s_       in         operand_value[31:0], opcode[33:32]  kind           end_of_expression
// m_       out        result_value[63:0]                  status[2:0]    -
//
// One token at a time: a push, an add or subtract, a multiply (four passes
// through the shared 32 x 32 multiplier) or a divide (one quotient bit per cycle
// for 96 bits; a zero divisor skips the divider) is finished before the next.
// A token marked last also goes through the final pop to the output register.
// Reset is synchronous and active low; it empties the stack and clears status.
// The output register lets a token be accepted while a result waits on m_tready;
// only the final pop of the next expression stalls for it.
module rpn_stack_evaluator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // operand_value[31:0], operator_code[33:32]
    input  logic                 s_tuser,   // kind
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [VALUE_W-1:0]   m_tdata,   // result_value[63:0]
    output logic [STATUS_W-1:0]  m_tuser    // status[2:0]
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rpn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rpn_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

FILE: rtl/core/rpn_checker.sv
`include "rpn_stack_evaluator_macros.svh"

module rpn_checker
    import rpn_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [VALUE_W-1:0]   m_tdata,
    input logic [STATUS_W-1:0]  m_tuser
);

    // Tokens are worked one at a time, so ready drops right after a transfer.
    `RPN_ASSERT_NEXT(a_one_token, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input ready after transfer")

    // A result is raised only from the final pop, never while tokens are taken.
    `RPN_ASSERT_NOW(a_emit_busy, aclk, aresetn, $rose(m_tvalid), !$past(s_tready), "result raised while idle")

    // A result waiting on the output holds its value and status.
    `RPN_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind rpn_stack_evaluator rpn_checker u_rpn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/rpn_stack_evaluator_test.sv
module rpn_stack_evaluator_test;
    import rpn_pkg::*;

    localparam int DEPTH         = DEFAULT_STACK_DEPTH;
    localparam int RANDOM_TOKENS = 700;
    localparam int DRAIN_CYCLES  = 150;

    typedef struct {
        logic                 kind;
        logic [OPERAND_W-1:0] operand;
        opcode_t              opcode;
        logic                 last;
    } token_t;

    typedef struct {
        fx_t     value;
        status_t status;
    } result_t;

    typedef struct {
        token_t  tok;
        bit      typed;
        result_t want;
    } row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // operand_value[31:0], operator_code[33:32]
    logic                 s_tuser;   // kind
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [VALUE_W-1:0]   m_tdata;   // result_value[63:0]
    logic [STATUS_W-1:0]  m_tuser;   // status[2:0]

    // Model of the evaluator state.
    fx_t     calc_stack [DEPTH];
    int      calc_depth;
    status_t calc_status;

    result_t pending_results[$];
    row_t    directed_rows[$];

    int mismatch_count;
    int tokens_sent;
    int results_checked;
    int status_seen[5];
    bit calm;

    always #5 aclk = ~aclk;

    rpn_stack_evaluator #(.STACK_DEPTH(DEPTH)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Only the first error of an expression is kept.
    function automatic void note_status(status_t code);
        if (calc_status == ST_OK) begin
            calc_status = code;
        end
    endfunction

    function automatic fx_t clamp_mag(fx_t mag, bit neg, bit ovf);
        if (neg) begin
            if (ovf || mag > FX_NEG_MIN) begin
                note_status(ST_SAT);
                return FX_NEG_MIN;
            end
            return -mag;
        end
        if (ovf || mag > FX_POS_MAX) begin
            note_status(ST_SAT);
            return FX_POS_MAX;
        end
        return mag;
    endfunction

    function automatic fx_t apply_operator(opcode_t op, fx_t a, fx_t b);
        fx_t          r;
        fx_t          ua;
        fx_t          ub;
        bit           neg;
        logic [127:0] wide;
        neg = a[VALUE_W-1] ^ b[VALUE_W-1];
        ua  = a[VALUE_W-1] ? -a : a;
        ub  = b[VALUE_W-1] ? -b : b;
        case (op)
            OP_ADD: begin
                r = a + b;
                if (a[VALUE_W-1] == b[VALUE_W-1] && r[VALUE_W-1] != a[VALUE_W-1]) begin
                    note_status(ST_SAT);
                    r = a[VALUE_W-1] ? FX_NEG_MIN : FX_POS_MAX;
                end
            end
            OP_SUB: begin
                r = a - b;
                if (a[VALUE_W-1] != b[VALUE_W-1] && r[VALUE_W-1] != a[VALUE_W-1]) begin
                    note_status(ST_SAT);
                    r = a[VALUE_W-1] ? FX_NEG_MIN : FX_POS_MAX;
                end
            end
            OP_MUL: begin
                wide = {64'b0, ua} * {64'b0, ub};
                r = clamp_mag(wide[95:32], neg, |wide[127:96]);
            end
            default: begin
                if (ub == '0) begin
                    note_status(ST_DIVZERO);
                    r = '0;
                end else begin
                    wide = {32'b0, ua, 32'b0} / {64'b0, ub};
                    // A quotient whose low 64 bits are zero loses its sign,
                    // even when the upper bits force saturation.
                    if (wide[63:0] == '0) begin
                        neg = 1'b0;
                    end
                    r = clamp_mag(wide[63:0], neg, |wide[127:64]);
                end
            end
        endcase
        return r;
    endfunction

    function automatic bit evaluate_token(token_t t, output result_t res);
        res.value  = '0;
        res.status = ST_OK;
        if (t.kind == KIND_PUSH) begin
            if (calc_depth >= DEPTH) begin
                note_status(ST_OVER);
            end else begin
                calc_stack[calc_depth] = {t.operand, 32'b0};
                calc_depth++;
            end
        end else if (calc_depth < 2) begin
            note_status(ST_UNDER);
        end else begin
            calc_stack[calc_depth-2] = apply_operator(t.opcode, calc_stack[calc_depth-2],
                                                      calc_stack[calc_depth-1]);
            calc_depth--;
        end
        if (!t.last) begin
            return 1'b0;
        end
        if (calc_depth == 0) begin
            note_status(ST_UNDER);
        end else begin
            res.value = calc_stack[calc_depth-1];
        end
        res.status  = calc_status;
        calc_depth  = 0;
        calc_status = ST_OK;
        return 1'b1;
    endfunction

    function automatic void add_row(logic kind, logic [OPERAND_W-1:0] operand, opcode_t op,
                                    logic last, bit typed, fx_t value, status_t status);
        row_t r;
        r.tok.kind    = kind;
        r.tok.operand = operand;
        r.tok.opcode  = op;
        r.tok.last    = last;
        r.typed       = typed;
        r.want.value  = value;
        r.want.status = status;
        directed_rows.push_back(r);
    endfunction

    function automatic logic [OPERAND_W-1:0] rand_operand();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return OPERAND_W'($urandom_range(0, 20)) - 32'd10;
            5, 6:          return $urandom;
            7:             return 32'h7FFF_FFFF;
            8:             return 32'h8000_0000;
            default:       return OPERAND_W'($urandom_range(0, 65535)) - 32'd32768;
        endcase
    endfunction

    function automatic token_t rand_token(logic kind);
        token_t t;
        t.kind    = kind;
        t.operand = (kind == KIND_PUSH) ? rand_operand() : OPERAND_W'($urandom);
        t.opcode  = opcode_t'($urandom_range(0, 3));
        t.last    = 1'b0;
        return t;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_token(token_t t, bit typed, result_t want);
        int      gap;
        result_t res;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({t.opcode, t.operand});
        s_tuser  <= t.kind;
        s_tlast  <= t.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (evaluate_token(t, res)) begin
            pending_results.push_back(typed ? want : res);
        end
        tokens_sent++;
        @(negedge aclk);
    endtask

    initial begin
        token_t  expr[$];
        token_t  t;
        int      random_sent;
        int      n_push;
        int      n_ops;
        int      pushed;
        int      depth;
        result_t none;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = KIND_PUSH;
        s_tlast     = 1'b0;
        calc_depth  = 0;
        calc_status = ST_OK;
        none.value  = '0;
        none.status = ST_OK;

        // Operator and end on an empty stack right after reset.
        add_row(KIND_OPER, 32'h0, OP_ADD, 1'b1, 1'b1, '0, ST_UNDER);
        // Largest and smallest operands pass through unchanged.
        add_row(KIND_PUSH, 32'h7FFF_FFFF, OP_ADD, 1'b1, 1'b1, 64'h7FFF_FFFF_0000_0000, ST_OK);
        add_row(KIND_PUSH, 32'h8000_0000, OP_ADD, 1'b1, 1'b1, 64'h8000_0000_0000_0000, ST_OK);
        // Product of the two largest operands saturates high.
        add_row(KIND_PUSH, 32'h7FFF_FFFF, OP_ADD, 1'b0, 1'b0, '0, ST_OK);
        add_row(KIND_PUSH, 32'h7FFF_FFFF, OP_ADD, 1'b0, 1'b0, '0, ST_OK);
        add_row(KIND_OPER, 32'h0, OP_MUL, 1'b1, 1'b1, FX_POS_MAX, ST_SAT);
        // Divide by zero leaves a zero on the stack.
        add_row(KIND_PUSH, 32'd5, OP_ADD, 1'b0, 1'b0, '0, ST_OK);
        add_row(KIND_PUSH, 32'd0, OP_ADD, 1'b0, 1'b0, '0, ST_OK);
        add_row(KIND_OPER, 32'h0, OP_DIV, 1'b1, 1'b1, '0, ST_DIVZERO);
        // Sum of the two most negative operands saturates low.
        add_row(KIND_PUSH, 32'h8000_0000, OP_ADD, 1'b0, 1'b0, '0, ST_OK);
        add_row(KIND_PUSH, 32'h8000_0000, OP_ADD, 1'b0, 1'b0, '0, ST_OK);
        add_row(KIND_OPER, 32'h0, OP_ADD, 1'b1, 1'b1, FX_NEG_MIN, ST_SAT);
        // An underflow followed by a divide by zero reports the underflow.
        add_row(KIND_PUSH, 32'd1, OP_ADD, 1'b0, 1'b0, '0, ST_OK);
        add_row(KIND_OPER, 32'h0, OP_MUL, 1'b0, 1'b0, '0, ST_OK);
        add_row(KIND_PUSH, 32'd0, OP_ADD, 1'b0, 1'b0, '0, ST_OK);
        add_row(KIND_OPER, 32'h0, OP_DIV, 1'b1, 1'b1, '0, ST_UNDER);
        // Fractional quotient after a subtraction.
        add_row(KIND_PUSH, 32'd7, OP_ADD, 1'b0, 1'b0, '0, ST_OK);
        add_row(KIND_PUSH, 32'd2, OP_ADD, 1'b0, 1'b0, '0, ST_OK);
        add_row(KIND_OPER, 32'h0, OP_SUB, 1'b0, 1'b0, '0, ST_OK);
        add_row(KIND_PUSH, 32'd3, OP_ADD, 1'b0, 1'b0, '0, ST_OK);
        add_row(KIND_OPER, 32'h0, OP_DIV, 1'b1, 1'b0, '0, ST_OK);
        // Negative quotient truncates toward zero.
        add_row(KIND_PUSH, 32'hFFFF_FFF9, OP_ADD, 1'b0, 1'b0, '0, ST_OK);
        add_row(KIND_PUSH, 32'd2, OP_ADD, 1'b0, 1'b0, '0, ST_OK);
        add_row(KIND_OPER, 32'h0, OP_DIV, 1'b1, 1'b0, '0, ST_OK);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            send_token(directed_rows[i].tok, directed_rows[i].typed, directed_rows[i].want);
        end

        random_sent = 0;
        while (random_sent < RANDOM_TOKENS) begin
            if ($urandom_range(0, 7) == 0) begin
                calm = !calm;
            end
            expr.delete();
            case ($urandom_range(0, 9))
                7: begin
                    // Deep run that walks the stack to near full, to full or past it.
                    n_push = $urandom_range(DEPTH - 2, DEPTH + 3);
                    n_ops  = $urandom_range(0, DEPTH + 2);
                    repeat (n_push) expr.push_back(rand_token(KIND_PUSH));
                    repeat (n_ops) expr.push_back(rand_token(KIND_OPER));
                end
                8, 9: begin
                    repeat ($urandom_range(1, 6)) begin
                        expr.push_back(rand_token(logic'($urandom_range(0, 1))));
                    end
                end
                default: begin
                    n_push = $urandom_range(1, 8);
                    pushed = 0;
                    depth  = 0;
                    while (pushed < n_push || depth > 1) begin
                        if (pushed < n_push && (depth < 2 || $urandom_range(0, 2) != 0)) begin
                            expr.push_back(rand_token(KIND_PUSH));
                            pushed++;
                            depth++;
                        end else begin
                            expr.push_back(rand_token(KIND_OPER));
                            depth--;
                        end
                    end
                end
            endcase
            expr[expr.size()-1].last = 1'b1;
            foreach (expr[i]) begin
                t = expr[i];
                send_token(t, 1'b0, none);
                random_sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d tokens (%0d directed) and checked %0d results.",
                 tokens_sent, directed_rows.size(), results_checked);
        $display("Status seen: ok %0d, underflow %0d, overflow %0d, div by zero %0d, sat %0d.",
                 status_seen[ST_OK], status_seen[ST_UNDER], status_seen[ST_OVER],
                 status_seen[ST_DIVZERO], status_seen[ST_SAT]);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Result side: random stalls on m_tready, each transfer checked in order.
    initial begin
        int      stall;
        result_t want;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            results_checked++;
            if (m_tuser < 5) begin
                status_seen[m_tuser]++;
            end
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: result_value %h, status %0d",
                       m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata !== want.value) begin
                    $error("result_value: expected %h, got %h", want.value, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    mismatch_count++;
                end
            end
            @(negedge aclk);
        end
    end

    initial begin
        #5000000;
        $display("Timed out with %0d results outstanding.", pending_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
